// ===== hw/rtl/pid_controller_step_unit_defines.svh =====
// assertion macros shared by the pid step unit rtl
// needs signals clk and rst_n in the scope where a macro is used
`ifndef PID_CONTROLLER_STEP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_STEP_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PIDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pidc_pkg.sv =====
// shared types, codes and fixed point helpers for the pid step unit
// no dependencies
package pidc_pkg;

    typedef logic signed [67:0] wide_t;

    localparam logic signed [33:0] QPi    = 34'sd205887;
    localparam logic signed [33:0] QTwoPi = 34'sd411774;
    localparam logic [16:0]        QOne   = 17'd65536;

    localparam wide_t Max32 = 68'sd2147483647;
    localparam wide_t Min32 = -68'sd2147483648;

    typedef enum logic [1:0] {
        OP_MEAS  = 2'd0,
        OP_RATE  = 2'd1,
        OP_PAUSE = 2'd2,
        OP_ALIAS = 2'd3
    } op_code_t;

    typedef enum logic [2:0] {
        R_GAIN_P   = 3'd0,
        R_GAIN_I   = 3'd1,
        R_GAIN_D   = 3'd2,
        R_STEP     = 3'd3,
        R_WEIGHT   = 3'd4,
        R_OUT_LIM  = 3'd5,
        R_INT_LIM  = 3'd6,
        R_MODE     = 3'd7
    } reg_idx_t;

    typedef enum logic [4:0] {
        C_NONE,
        C_LOAD,
        C_X_FB,
        C_X_ERR,
        C_DIV_WRAP,
        C_SET_DIFF,
        C_SET_ERR,
        C_MUL_F1,
        C_MUL_F2,
        C_SET_FILT,
        C_MUL_P,
        C_SET_P,
        C_MUL_T,
        C_SET_T,
        C_DIV_DYN,
        C_SET_EKI,
        C_MUL_I,
        C_SET_I,
        C_MUL_D,
        C_DIV_D,
        C_SET_D,
        C_OUT
    } pidc_cmd_t;

    typedef struct packed {
        logic measured;
        logic wrap;
        logic dyn;
        logic div_done;
        logic out_full;
        logic out_free;
    } pidc_status_t;

    // floor((v + 2^(s-1)) / 2^s)
    function automatic wide_t rnd_shr(input wide_t v, input int unsigned s);
        wide_t half;
        half = wide_t'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > Max32)
            r = 32'sh7fffffff;
        else if (v < Min32)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_sym(input wide_t v, input logic [30:0] lim);
        wide_t l;
        wide_t nl;
        logic signed [31:0] r;
        l  = wide_t'({37'b0, lim});
        nl = -l;
        if (v > l)
            r = l[31:0];
        else if (v < nl)
            r = nl[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [32:0] abs32(input logic signed [31:0] x);
        logic signed [32:0] w;
        w = 33'(x);
        return w[32] ? 33'(-w) : 33'(w);
    endfunction

endpackage

// ===== hw/rtl/pidc_ifs.sv =====
// valid/ready channel interfaces of the pid step unit: request, response, config
// no dependencies
interface pidc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] setpoint;
    logic [31:0] feedback;
    logic [31:0] setpoint_rate;
    logic [31:0] feedback_rate;
    logic [30:0] pause_threshold;

    modport source (output valid, op, setpoint, feedback, setpoint_rate, feedback_rate,
                    pause_threshold, input ready);
    modport sink (input valid, op, setpoint, feedback, setpoint_rate, feedback_rate,
                  pause_threshold, output ready);
endinterface

interface pidc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] drive;
    logic [31:0] p_term;
    logic [31:0] i_term;
    logic [31:0] d_term;

    modport source (output valid, drive, p_term, i_term, d_term, input ready);
    modport sink (input valid, drive, p_term, i_term, d_term, output ready);
endinterface

interface pidc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pid_controller_step_unit.sv =====
// top level of the pid step unit: controller plus datapath behind three channels
// depends on pidc_pkg, pidc_ifs, pidc_datapath and pidc_controller
//
// usage
// - req carries one control step: op, setpoint, feedback, rates, pause threshold
// - rsp returns drive, p_term, i_term and d_term, one transaction per request
// - cfg writes a register by index (gains, step time, filter weight, limits, mode)
//   and is always ready; write only while no step is in flight
// - one step at a time: req.ready is high only while the sequencer is idle
// - angular mode wraps the error, and on measured ops the feedback difference too,
//   by a reciprocal multiply and one correcting subtract
// - the bit-serial divider (64 iterations) serves the error-dependent gain and the
//   measured derivative: 0 to 2 passes per step
// - the result sits in an output register; the next request is taken in the cycle
//   after it is written, and a stalled receiver only holds the final write
// - reset clears gains and history, sets step time and weight to one and the
//   limits to full scale; no result is pending after reset
module pid_controller_step_unit (
    input  logic        clk,
    input  logic        rst_n,
    pidc_req_if.sink    req,
    pidc_rsp_if.source  rsp,
    pidc_cfg_if.sink    cfg
);

    pidc_pkg::pidc_cmd_t    cmd;
    pidc_pkg::pidc_status_t status;

    // config channel never stalls
    assign cfg.ready = 1'b1;

    // sequencer: at most one command per cycle to the datapath, none while it waits
    pidc_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: shared multiplier, divider, state and result register
    pidc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (req.op),
        .setpoint        (req.setpoint),
        .feedback        (req.feedback),
        .setpoint_rate   (req.setpoint_rate),
        .feedback_rate   (req.feedback_rate),
        .pause_threshold (req.pause_threshold),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .drive           (rsp.drive),
        .p_term          (rsp.p_term),
        .i_term          (rsp.i_term),
        .d_term          (rsp.d_term)
    );

endmodule

// ===== hw/rtl/pidc_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle, unsigned operands
// depends on nothing but the clock and reset
module pidc_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [33:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    localparam int Steps = 64;
    localparam int CntW  = $clog2(Steps);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] count_reg;
    logic [63:0]     quot_reg;
    logic [33:0]     rem_reg;
    logic [33:0]     div_reg;

    logic [34:0] trial;
    logic        fits;
    logic [34:0] trial_sub;

    assign trial     = {rem_reg, quot_reg[63]};
    assign fits      = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CntW'(Steps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[62:0], fits};
            rem_reg  <= fits ? trial_sub[33:0] : trial[33:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== hw/rtl/pidc_datapath.sv =====
// datapath of the pid step unit: config and loop state, shared multiplier, divider
// depends on pidc_pkg and pidc_divider
module pidc_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pidc_pkg::pidc_cmd_t   cmd,
    output pidc_pkg::pidc_status_t status,
    input  logic [1:0]            op,
    input  logic [31:0]           setpoint,
    input  logic [31:0]           feedback,
    input  logic [31:0]           setpoint_rate,
    input  logic [31:0]           feedback_rate,
    input  logic [30:0]           pause_threshold,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [31:0]           drive,
    output logic [31:0]           p_term,
    output logic [31:0]           i_term,
    output logic [31:0]           d_term
);

    // floor(2^33 / 2 pi); the quotient estimate is low by at most one
    localparam logic [14:0] WrapRecip = 15'd20860;
    localparam logic [33:0] TwoPiU    = $unsigned(pidc_pkg::QTwoPi);

    // configuration
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]        step_time_reg, out_lim_reg, int_lim_reg;
    logic [16:0]        weight_reg;
    logic [1:0]         mode_reg;

    // loop state
    logic signed [31:0] prev_fb_reg, filt_reg, perr_reg, acc_reg;
    logic               out_valid_reg;

    // latched item and scratch
    logic [1:0]         op_reg;
    logic signed [31:0] sp_reg, fb_reg, spr_reg, fbr_reg;
    logic [30:0]        thr_reg;
    logic signed [32:0] x_reg;
    logic signed [31:0] diff_reg, err_reg, p_reg, trap_reg, eki_reg, d_reg;
    pidc_pkg::wide_t    prod_reg, sum_reg;
    logic signed [31:0] drive_reg, pout_reg, iout_reg, dout_reg;

    logic [30:0]        dt_eff;
    logic [16:0]        alpha_eff;
    logic               measured;
    logic signed [33:0] mul_a, mul_b;
    pidc_pkg::wide_t    mul_p;

    logic               div_start, div_done;
    logic [63:0]        div_dividend, div_quot;
    logic [33:0]        div_divisor;

    // angular wrap: reciprocal multiply, then one correcting subtract
    logic [47:0]        wrap_prod;
    logic [14:0]        wq_reg;
    logic [33:0]        wq_mul;
    logic [33:0]        wrem_raw;
    logic [33:0]        wrem_fix;
    logic [33:0]        wrem_reg;
    logic               wstep_reg;

    logic signed [33:0] v_wrap;
    logic [33:0]        v_mag;
    logic signed [33:0] r_wrap;
    logic signed [31:0] wrapped, wrap_or_sat;
    pidc_pkg::wide_t    prod_mag, q_wide, q_eki, q_d;
    logic [32:0]        gi_mag, err_mag, p_mag;
    logic               pause;

    assign dt_eff    = (step_time_reg == '0) ? 31'd1 : step_time_reg;
    assign alpha_eff = (weight_reg > pidc_pkg::QOne) ? pidc_pkg::QOne : weight_reg;
    assign measured  = (op_reg != pidc_pkg::OP_RATE);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            pidc_pkg::C_MUL_F1:
            begin
                mul_a = $signed({17'b0, alpha_eff});
                mul_b = 34'(diff_reg);
            end
            pidc_pkg::C_MUL_F2:
            begin
                mul_a = $signed({17'b0, 17'(pidc_pkg::QOne - alpha_eff)});
                mul_b = 34'(filt_reg);
            end
            pidc_pkg::C_MUL_P:
            begin
                mul_a = 34'(gain_p_reg);
                mul_b = 34'(err_reg);
            end
            pidc_pkg::C_MUL_T:
            begin
                mul_a = 34'(err_reg) + 34'(perr_reg);
                mul_b = $signed({3'b0, dt_eff});
            end
            pidc_pkg::C_MUL_I:
            begin
                mul_a = 34'(eki_reg);
                mul_b = 34'(trap_reg);
            end
            pidc_pkg::C_MUL_D:
            begin
                mul_a = 34'(gain_d_reg);
                mul_b = measured ? 34'(filt_reg) : 34'(spr_reg) - 34'(fbr_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 68'(mul_a) * 68'(mul_b);

    // angular wrap from the remainder of (x + pi) by 2 pi
    assign v_wrap    = 34'(x_reg) + pidc_pkg::QPi;
    assign v_mag     = v_wrap[33] ? 34'(-v_wrap) : v_wrap;
    assign wrap_prod = {14'b0, v_mag} * 48'(WrapRecip);
    assign wq_mul    = {19'b0, wq_reg} * TwoPiU;
    assign wrem_raw  = v_mag - wq_mul;
    assign wrem_fix  = (wrem_raw >= TwoPiU) ? wrem_raw - TwoPiU : wrem_raw;
    assign r_wrap  = (v_wrap[33] && wrem_reg != '0) ? pidc_pkg::QTwoPi - $signed(wrem_reg)
                                                   : $signed(wrem_reg);
    assign wrapped = 32'(r_wrap - pidc_pkg::QPi);
    assign wrap_or_sat = mode_reg[0] ? wrapped : pidc_pkg::sat32(68'(x_reg));

    assign gi_mag   = pidc_pkg::abs32(gain_i_reg);
    assign err_mag  = pidc_pkg::abs32(err_reg);
    assign p_mag    = pidc_pkg::abs32(p_reg);
    assign prod_mag = prod_reg[67] ? -prod_reg : prod_reg;
    assign pause    = (op_reg == pidc_pkg::OP_PAUSE) && (p_mag > {2'b0, thr_reg});

    assign div_start = (cmd == pidc_pkg::C_DIV_DYN) || (cmd == pidc_pkg::C_DIV_D);

    always_comb
    begin
        div_dividend = '0;
        div_divisor  = 34'd1;
        case (cmd)
            pidc_pkg::C_DIV_DYN:
            begin
                div_dividend = {15'b0, gi_mag, 16'b0};
                div_divisor  = 34'(pidc_pkg::QOne) + {1'b0, err_mag};
            end
            pidc_pkg::C_DIV_D:
            begin
                div_dividend = prod_mag[63:0];
                div_divisor  = {3'b0, dt_eff};
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 34'd1;
            end
        endcase
    end

    pidc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot)
    );

    assign q_wide = pidc_pkg::wide_t'({4'b0, div_quot});
    assign q_eki  = gain_i_reg[31] ? -q_wide : q_wide;
    assign q_d    = prod_reg[67] ? -q_wide : q_wide;

    // control state, configuration and loop history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            step_time_reg <= 31'd65536;
            weight_reg    <= 17'd65536;
            out_lim_reg   <= 31'h7fffffff;
            int_lim_reg   <= 31'h7fffffff;
            mode_reg      <= '0;
            prev_fb_reg   <= '0;
            filt_reg      <= '0;
            perr_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            wstep_reg     <= 1'b0;
        end
        else
        begin
            wstep_reg <= (cmd == pidc_pkg::C_DIV_WRAP);

            if (cfg_we)
            begin
                case (pidc_pkg::reg_idx_t'(cfg_index))
                    pidc_pkg::R_GAIN_P:  gain_p_reg    <= cfg_data;
                    pidc_pkg::R_GAIN_I:  gain_i_reg    <= cfg_data;
                    pidc_pkg::R_GAIN_D:  gain_d_reg    <= cfg_data;
                    pidc_pkg::R_STEP:    step_time_reg <= cfg_data[30:0];
                    pidc_pkg::R_WEIGHT:  weight_reg    <= cfg_data[16:0];
                    pidc_pkg::R_OUT_LIM: out_lim_reg   <= cfg_data[30:0];
                    pidc_pkg::R_INT_LIM: int_lim_reg   <= cfg_data[30:0];
                    pidc_pkg::R_MODE:    mode_reg      <= cfg_data[1:0];
                    default:             mode_reg      <= mode_reg;
                endcase
            end

            case (cmd)
                pidc_pkg::C_SET_FILT:
                begin
                    filt_reg    <= pidc_pkg::sat32(pidc_pkg::rnd_shr(sum_reg + prod_reg, 16));
                    prev_fb_reg <= fb_reg;
                end
                pidc_pkg::C_SET_T: perr_reg <= err_reg;
                pidc_pkg::C_SET_I:
                    acc_reg <= pidc_pkg::clamp_sym(68'(acc_reg) +
                               pidc_pkg::rnd_shr(prod_reg, 16), int_lim_reg);
                default: acc_reg <= acc_reg;
            endcase

            if (cmd == pidc_pkg::C_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item payload and scratch registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            pidc_pkg::C_LOAD:
            begin
                op_reg  <= op;
                sp_reg  <= setpoint;
                fb_reg  <= feedback;
                spr_reg <= setpoint_rate;
                fbr_reg <= feedback_rate;
                thr_reg <= pause_threshold;
            end
            pidc_pkg::C_X_FB:     x_reg    <= 33'(prev_fb_reg) - 33'(fb_reg);
            pidc_pkg::C_X_ERR:    x_reg    <= 33'(sp_reg) - 33'(fb_reg);
            pidc_pkg::C_DIV_WRAP: wq_reg   <= wrap_prod[47:33];
            pidc_pkg::C_SET_DIFF: diff_reg <= wrap_or_sat;
            pidc_pkg::C_SET_ERR:  err_reg  <= wrap_or_sat;
            pidc_pkg::C_MUL_F1,
            pidc_pkg::C_MUL_P,
            pidc_pkg::C_MUL_T,
            pidc_pkg::C_MUL_I,
            pidc_pkg::C_MUL_D:    prod_reg <= mul_p;
            pidc_pkg::C_MUL_F2:
            begin
                sum_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            pidc_pkg::C_SET_P:    p_reg <= pidc_pkg::sat32(pidc_pkg::rnd_shr(prod_reg, 16));
            pidc_pkg::C_SET_T:
                trap_reg <= pause ? 32'sd0 : pidc_pkg::sat32(pidc_pkg::rnd_shr(prod_reg, 17));
            pidc_pkg::C_SET_EKI:  eki_reg <= status.dyn ? q_eki[31:0] : gain_i_reg;
            pidc_pkg::C_SET_D:
                d_reg <= measured ? pidc_pkg::sat32(q_d)
                                  : pidc_pkg::sat32(pidc_pkg::rnd_shr(prod_reg, 16));
            pidc_pkg::C_OUT:
            begin
                drive_reg <= pidc_pkg::clamp_sym(68'(p_reg) + 68'(acc_reg) + 68'(d_reg),
                                                 out_lim_reg);
                pout_reg  <= p_reg;
                iout_reg  <= acc_reg;
                dout_reg  <= d_reg;
            end
            default: x_reg <= x_reg;
        endcase

        // wrap remainder lands in the cycle after the estimate
        if (wstep_reg)
            wrem_reg <= wrem_fix;
    end

    assign status.measured = measured;
    assign status.wrap     = mode_reg[0];
    assign status.dyn      = measured & mode_reg[1];
    assign status.div_done = div_done | wstep_reg;
    assign status.out_full = out_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign p_term    = pout_reg;
    assign i_term    = iout_reg;
    assign d_term    = dout_reg;

endmodule

// ===== hw/rtl/pidc_controller.sv =====
// sequencer of the pid step unit, issues at most one datapath command per cycle, none while it waits
// depends on pidc_pkg and pid_controller_step_unit_defines.svh
`include "pid_controller_step_unit_defines.svh"

module pidc_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pidc_pkg::pidc_status_t status,
    output pidc_pkg::pidc_cmd_t    cmd
);

    localparam int Ns = 27;

    typedef enum logic [Ns-1:0] {
        S_IDLE      = Ns'(1) << 0,
        S_START     = Ns'(1) << 1,
        S_XFB       = Ns'(1) << 2,
        S_WFB_DIV   = Ns'(1) << 3,
        S_WFB_WAIT  = Ns'(1) << 4,
        S_SETDIFF   = Ns'(1) << 5,
        S_MF1       = Ns'(1) << 6,
        S_MF2       = Ns'(1) << 7,
        S_SETFILT   = Ns'(1) << 8,
        S_XERR      = Ns'(1) << 9,
        S_WERR_DIV  = Ns'(1) << 10,
        S_WERR_WAIT = Ns'(1) << 11,
        S_SETERR    = Ns'(1) << 12,
        S_MP        = Ns'(1) << 13,
        S_SETP      = Ns'(1) << 14,
        S_MT        = Ns'(1) << 15,
        S_SETT      = Ns'(1) << 16,
        S_DYN_DIV   = Ns'(1) << 17,
        S_DYN_WAIT  = Ns'(1) << 18,
        S_SETEKI    = Ns'(1) << 19,
        S_MI        = Ns'(1) << 20,
        S_SETI      = Ns'(1) << 21,
        S_MD        = Ns'(1) << 22,
        S_DDIV      = Ns'(1) << 23,
        S_DWAIT     = Ns'(1) << 24,
        S_SETD      = Ns'(1) << 25,
        S_OUT       = Ns'(1) << 26
    } pidc_state_t;

    pidc_state_t state_reg, state_next;

    logic accepted;
    logic in_wait;
    logic out_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = pidc_pkg::C_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = pidc_pkg::C_LOAD;
                    state_next = S_START;
                end
            end
            S_START: state_next = status.measured ? S_XFB : S_XERR;
            S_XFB:
            begin
                cmd        = pidc_pkg::C_X_FB;
                state_next = status.wrap ? S_WFB_DIV : S_SETDIFF;
            end
            S_WFB_DIV:
            begin
                cmd        = pidc_pkg::C_DIV_WRAP;
                state_next = S_WFB_WAIT;
            end
            S_WFB_WAIT: if (status.div_done) state_next = S_SETDIFF;
            S_SETDIFF:
            begin
                cmd        = pidc_pkg::C_SET_DIFF;
                state_next = S_MF1;
            end
            S_MF1:
            begin
                cmd        = pidc_pkg::C_MUL_F1;
                state_next = S_MF2;
            end
            S_MF2:
            begin
                cmd        = pidc_pkg::C_MUL_F2;
                state_next = S_SETFILT;
            end
            S_SETFILT:
            begin
                cmd        = pidc_pkg::C_SET_FILT;
                state_next = S_XERR;
            end
            S_XERR:
            begin
                cmd        = pidc_pkg::C_X_ERR;
                state_next = status.wrap ? S_WERR_DIV : S_SETERR;
            end
            S_WERR_DIV:
            begin
                cmd        = pidc_pkg::C_DIV_WRAP;
                state_next = S_WERR_WAIT;
            end
            S_WERR_WAIT: if (status.div_done) state_next = S_SETERR;
            S_SETERR:
            begin
                cmd        = pidc_pkg::C_SET_ERR;
                state_next = S_MP;
            end
            S_MP:
            begin
                cmd        = pidc_pkg::C_MUL_P;
                state_next = S_SETP;
            end
            S_SETP:
            begin
                cmd        = pidc_pkg::C_SET_P;
                state_next = S_MT;
            end
            S_MT:
            begin
                cmd        = pidc_pkg::C_MUL_T;
                state_next = S_SETT;
            end
            S_SETT:
            begin
                cmd        = pidc_pkg::C_SET_T;
                state_next = status.dyn ? S_DYN_DIV : S_SETEKI;
            end
            S_DYN_DIV:
            begin
                cmd        = pidc_pkg::C_DIV_DYN;
                state_next = S_DYN_WAIT;
            end
            S_DYN_WAIT: if (status.div_done) state_next = S_SETEKI;
            S_SETEKI:
            begin
                cmd        = pidc_pkg::C_SET_EKI;
                state_next = S_MI;
            end
            S_MI:
            begin
                cmd        = pidc_pkg::C_MUL_I;
                state_next = S_SETI;
            end
            S_SETI:
            begin
                cmd        = pidc_pkg::C_SET_I;
                state_next = S_MD;
            end
            S_MD:
            begin
                cmd        = pidc_pkg::C_MUL_D;
                state_next = status.measured ? S_DDIV : S_SETD;
            end
            S_DDIV:
            begin
                cmd        = pidc_pkg::C_DIV_D;
                state_next = S_DWAIT;
            end
            S_DWAIT: if (status.div_done) state_next = S_SETD;
            S_SETD:
            begin
                cmd        = pidc_pkg::C_SET_D;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd        = pidc_pkg::C_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign accepted = in_valid && in_ready;
    assign in_wait  = (state_reg == S_WFB_WAIT) || (state_reg == S_WERR_WAIT) ||
                      (state_reg == S_DYN_WAIT) || (state_reg == S_DWAIT);
    assign out_cmd  = (cmd == pidc_pkg::C_OUT);

    `PIDC_ASSERT_NEXT(a_accept_starts, accepted, state_reg == S_START, "accepted item did not start")
    `PIDC_ASSERT_SAME(a_done_in_wait, status.div_done, in_wait, "divider finished outside a wait")
    `PIDC_ASSERT_NEXT(a_out_written, out_cmd, status.out_full, "result write did not raise valid")

endmodule
